// ----- rtl/bitmap_select_engine_defines.svh -----
// Assertion macros shared by the checker of the bitmap select engine.
// Depends on nothing; the including module supplies clk and rst.
`ifndef BITMAP_SELECT_ENGINE_DEFINES_SVH
`define BITMAP_SELECT_ENGINE_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define BSE_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("bitmap_select_engine check failed");

// Next-cycle implication, evaluated during reset as well.
`define BSE_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) (cond) |=> (expr)) \
    else $error("bitmap_select_engine check failed");

`endif

// ----- rtl/bse_pkg.sv -----
// Shared types and constants of the bitmap select engine.
// Depends on nothing.
package bse_pkg;

  localparam int WORD_COUNT_DEF = 1024;
  localparam int WORD_BITS      = 64;
  localparam int POS_W          = 17;

  localparam logic [3:0] MODE_SET     = 4'd0;
  localparam logic [3:0] MODE_COMBINE = 4'd1;
  localparam logic [3:0] MODE_FILL    = 4'd2;
  localparam logic [3:0] MODE_INVERT  = 4'd3;
  localparam logic [3:0] MODE_NEXT    = 4'd4;
  localparam logic [3:0] MODE_PREV    = 4'd5;
  localparam logic [3:0] MODE_LAST    = 4'd6;
  localparam logic [3:0] MODE_EMPTY   = 4'd7;
  localparam logic [3:0] MODE_COUNT   = 4'd8;

  localparam logic [2:0] COP_AND    = 3'd0;
  localparam logic [2:0] COP_OR     = 3'd1;
  localparam logic [2:0] COP_ANDNOT = 3'd2;
  localparam logic [2:0] COP_XOR    = 3'd3;
  localparam logic [2:0] COP_ORNOT  = 3'd4;
  localparam logic [2:0] COP_COPY   = 3'd5;

  typedef enum logic [2:0] {
    WF_SET,
    WF_CLR,
    WF_COMB,
    WF_FILL,
    WF_INV
  } wfn_t;

  typedef struct packed {
    logic       nonzero;
    logic [5:0] low_idx;
    logic [5:0] high_idx;
    logic [6:0] popcnt;
  } scan_t;

  typedef struct packed {
    logic [3:0]           mode;
    logic [15:0]          row_index;
    logic                 bit_value;
    logic [9:0]           word_index;
    logic [WORD_BITS-1:0] operand_word;
    logic [2:0]           combine_op;
    logic [7:0]           fill_byte;
    logic [16:0]          scan_limit;
    logic [9:0]           first_word;
    logic                 end_is_last;
  } cmd_t;

  typedef struct packed {
    logic                 found;
    logic [POS_W-1:0]     position;
    logic [WORD_BITS-1:0] word_after;
    logic                 all_clear;
  } result_t;

endpackage

// ----- rtl/bitmap_select_engine.sv -----
// Top level of the bitmap select engine: command sequencer around one word RAM.
// Depends on bse_pkg, bse_ram and bse_word_unit.
//
//   channel  | handshake           | payload
//   ---------+---------------------+----------------------
//   command  | start, busy         | cmd    (bse_pkg::cmd_t)
//   result   | done (one cycle)    | result (bse_pkg::result_t)
//
// Set and combine read, modify and write back one word before the done strobe.
// Fill, invert, count and the searches stream one RAM word per cycle through the
// single read port. Cases that touch no word give done in the next cycle. After
// reset, a clearing pass writes every word to zero and keeps busy high until it
// has written the last word. Results cannot be stalled.
module bitmap_select_engine #(
  parameter int WORD_COUNT = bse_pkg::WORD_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  bse_pkg::cmd_t    cmd,
  output logic             done,
  output bse_pkg::result_t result
);

  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int NZW        = $clog2(WORD_COUNT + 1);
  localparam int TOTAL_ROWS = WORD_COUNT * 64;
  localparam logic [AW-1:0] LAST_W = AW'(WORD_COUNT - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  typedef enum logic [3:0] {
    OP_CLEAR, OP_SET, OP_COMBINE, OP_FILL, OP_INVERT,
    OP_NEXT, OP_PREV, OP_LAST, OP_COUNT
  } op_t;

  state_t            state;
  op_t               op;
  bse_pkg::wfn_t     wfn;
  logic [AW-1:0]     addr, stop, first, paddr;
  logic              rd_on, pv;
  logic [63:0]       operand, mask_first, mask_stop;
  logic [2:0]        cop;
  logic [16:0]       cnt, cnt_next;
  logic [NZW-1:0]    nz, nz_next;

  logic [63:0]       rdata, word_out, unit_mask;
  bse_pkg::scan_t    scan;
  logic              we, accept, last_beat, dir_down;
  logic [17:0]       cnt_sum;

  // Command decode.
  logic [16:0]       row17, next_end, next_last;
  logic [9:0]        row_word;
  logic              row_in, widx_in, next_ok, prev_ok, last_ok;
  logic [AW-1:0]     last_end;

  always_comb begin
    row17    = {1'b0, cmd.row_index};
    row_word = cmd.row_index[15:6];
    row_in   = 32'(row_word) < WORD_COUNT;
    widx_in  = 32'(cmd.word_index) < WORD_COUNT;
    next_end = (32'(cmd.scan_limit) < TOTAL_ROWS) ? cmd.scan_limit : 17'(TOTAL_ROWS);
    next_last = next_end - 17'd1;
    next_ok  = (row17 <= cmd.scan_limit) && (row17 < next_end);
    prev_ok  = row17 <= cmd.scan_limit;
    last_end = (cmd.end_is_last || !widx_in) ? LAST_W : AW'(cmd.word_index);
    last_ok  = 32'(cmd.first_word) <= 32'(last_end);
  end

  assign busy     = state != S_IDLE;
  assign accept   = start && !busy;
  assign dir_down = (op == OP_PREV) || (op == OP_LAST);
  assign last_beat = paddr == stop;

  assign unit_mask = ((paddr == first) ? mask_first : '1) & (last_beat ? mask_stop : '1);

  assign we = (state == S_RUN) && pv &&
              ((op == OP_CLEAR) || (op == OP_SET) || (op == OP_COMBINE) ||
               (op == OP_FILL) || (op == OP_INVERT));

  bse_ram #(.WIDTH(64), .DEPTH(WORD_COUNT), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (paddr),
    .wdata (word_out),
    .raddr (addr),
    .rdata (rdata)
  );

  bse_word_unit u_unit (
    .word       (rdata),
    .mask       (unit_mask),
    .operand    (operand),
    .combine_op (cop),
    .fn         (wfn),
    .word_out   (word_out),
    .scan       (scan)
  );

  // Nonzero-word count tracks emptiness; the clearing pass leaves it at zero.
  always_comb begin
    nz_next = nz;
    if (we && (op != OP_CLEAR)) begin
      nz_next = nz + NZW'(word_out != '0) - NZW'(rdata != '0);
    end
    cnt_sum  = {1'b0, cnt} + 18'(scan.popcnt);
    cnt_next = cnt_sum[17] ? '1 : cnt_sum[16:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_RUN;
      op         <= OP_CLEAR;
      wfn        <= bse_pkg::WF_FILL;
      operand    <= '0;
      addr       <= '0;
      first      <= '0;
      stop       <= LAST_W;
      mask_first <= '1;
      mask_stop  <= '1;
      rd_on      <= 1'b1;
      pv         <= 1'b0;
      nz         <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      nz   <= nz_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            result     <= '{found: 1'b0, position: '0, word_after: '0,
                            all_clear: (nz == '0)};
            mask_first <= '1;
            mask_stop  <= '1;
            cop        <= cmd.combine_op;
            cnt        <= '0;
            pv         <= 1'b0;
            rd_on      <= 1'b1;
            state      <= S_RUN;
            unique case (cmd.mode)
              bse_pkg::MODE_SET: begin
                op      <= OP_SET;
                wfn     <= cmd.bit_value ? bse_pkg::WF_SET : bse_pkg::WF_CLR;
                operand <= 64'd1 << cmd.row_index[5:0];
                addr    <= AW'(row_word);
                first   <= AW'(row_word);
                stop    <= AW'(row_word);
                if (!row_in) begin
                  state <= S_IDLE;
                  done  <= 1'b1;
                end
              end
              bse_pkg::MODE_COMBINE: begin
                op      <= OP_COMBINE;
                wfn     <= bse_pkg::WF_COMB;
                operand <= cmd.operand_word;
                addr    <= AW'(cmd.word_index);
                first   <= AW'(cmd.word_index);
                stop    <= AW'(cmd.word_index);
                if (!widx_in) begin
                  state <= S_IDLE;
                  done  <= 1'b1;
                end
              end
              bse_pkg::MODE_FILL: begin
                op      <= OP_FILL;
                wfn     <= bse_pkg::WF_FILL;
                operand <= {8{cmd.fill_byte}};
                addr    <= '0;
                first   <= '0;
                stop    <= LAST_W;
              end
              bse_pkg::MODE_INVERT: begin
                op    <= OP_INVERT;
                wfn   <= bse_pkg::WF_INV;
                addr  <= '0;
                first <= '0;
                stop  <= LAST_W;
              end
              bse_pkg::MODE_NEXT: begin
                op         <= OP_NEXT;
                addr       <= AW'(row_word);
                first      <= AW'(row_word);
                stop       <= AW'(next_last[16:6]);
                mask_first <= '1 << cmd.row_index[5:0];
                mask_stop  <= '1 >> (6'd63 - next_last[5:0]);
                if (!next_ok) begin
                  state <= S_IDLE;
                  done  <= 1'b1;
                end
              end
              bse_pkg::MODE_PREV: begin
                op   <= OP_PREV;
                stop <= '0;
                // A start row beyond the store scans from the top word unmasked.
                if (row_in) begin
                  addr       <= AW'(row_word);
                  first      <= AW'(row_word);
                  mask_first <= '1 >> (6'd63 - cmd.row_index[5:0]);
                end else begin
                  addr  <= LAST_W;
                  first <= LAST_W;
                end
                if (!prev_ok) begin
                  state <= S_IDLE;
                  done  <= 1'b1;
                end
              end
              bse_pkg::MODE_LAST: begin
                op    <= OP_LAST;
                addr  <= last_end;
                first <= last_end;
                stop  <= AW'(cmd.first_word);
                if (!last_ok) begin
                  state <= S_IDLE;
                  done  <= 1'b1;
                end
              end
              bse_pkg::MODE_COUNT: begin
                op    <= OP_COUNT;
                addr  <= '0;
                first <= '0;
                stop  <= LAST_W;
              end
              default: begin
                state <= S_IDLE;
                done  <= 1'b1;
              end
            endcase
          end
        end
        S_RUN: begin
          if (rd_on) begin
            addr <= dir_down ? addr - AW'(1) : addr + AW'(1);
            if (addr == stop) begin
              rd_on <= 1'b0;
            end
          end
          pv    <= rd_on;
          paddr <= addr;
          if (pv) begin
            if (op == OP_COUNT) begin
              cnt <= cnt_next;
            end
            if (((op == OP_NEXT) || (op == OP_PREV) || (op == OP_LAST)) && scan.nonzero) begin
              state          <= S_IDLE;
              rd_on          <= 1'b0;
              pv             <= 1'b0;
              done           <= 1'b1;
              result.found   <= 1'b1;
              result.all_clear <= nz_next == '0;
              case (op)
                OP_NEXT: result.position <= 17'({paddr, scan.low_idx});
                OP_PREV: result.position <= 17'({paddr, scan.high_idx});
                default: result.position <= 17'(paddr);
              endcase
            end else if (last_beat) begin
              state            <= S_IDLE;
              rd_on            <= 1'b0;
              pv               <= 1'b0;
              done             <= op != OP_CLEAR;
              result.all_clear <= nz_next == '0;
              if (op == OP_COUNT) begin
                result.position <= cnt_next;
              end
              if ((op == OP_SET) || (op == OP_COMBINE)) begin
                result.word_after <= word_out;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/bse_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bse_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/bse_word_unit.sv -----
// Shared word datapath: bit write, combine, fill, invert, bit search and popcount.
// Depends on bse_pkg.
module bse_word_unit (
  input  logic [63:0]     word,
  input  logic [63:0]     mask,
  input  logic [63:0]     operand,
  input  logic [2:0]      combine_op,
  input  bse_pkg::wfn_t   fn,
  output logic [63:0]     word_out,
  output bse_pkg::scan_t  scan
);

  logic [63:0] masked;

  always_comb begin
    word_out = word;
    case (fn)
      bse_pkg::WF_SET:  word_out = word | operand;
      bse_pkg::WF_CLR:  word_out = word & ~operand;
      bse_pkg::WF_FILL: word_out = operand;
      bse_pkg::WF_INV:  word_out = ~word;
      default: begin
        case (combine_op)
          bse_pkg::COP_AND:    word_out = word & operand;
          bse_pkg::COP_OR:     word_out = word | operand;
          bse_pkg::COP_ANDNOT: word_out = word & ~operand;
          bse_pkg::COP_XOR:    word_out = word ^ operand;
          bse_pkg::COP_ORNOT:  word_out = word | ~operand;
          bse_pkg::COP_COPY:   word_out = operand;
          default:             word_out = word;
        endcase
      end
    endcase
  end

  assign masked = word & mask;

  always_comb begin
    scan.nonzero  = |masked;
    scan.low_idx  = '0;
    scan.high_idx = '0;
    scan.popcnt   = '0;
    for (int i = 63; i >= 0; i--) begin
      if (masked[i]) begin
        scan.low_idx = 6'(i);
      end
    end
    for (int i = 0; i < 64; i++) begin
      if (masked[i]) begin
        scan.high_idx = 6'(i);
      end
      scan.popcnt = scan.popcnt + 7'(masked[i]);
    end
  end

endmodule

// ----- rtl/bse_checker.sv -----
// Port-level checker for the bitmap select engine, bound to the top level.
// Depends on bse_pkg and bitmap_select_engine_defines.svh.
`include "bitmap_select_engine_defines.svh"

module bse_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input bse_pkg::result_t result
);

  // The clearing pass holds the engine busy right after reset.
  `BSE_ASSERT_NEXT(a_busy_after_reset, rst, busy)

  // A result beat only comes out as the engine returns to idle.
  `BSE_ASSERT_NOW(a_done_idle, done, !busy)

  // An accepted command either starts work or answers at once.
  `BSE_ASSERT_NEXT(a_accept_progress, !rst && start && !busy, rst || busy || done)

  // Only searches report a hit, and they never report a stored word.
  `BSE_ASSERT_NOW(a_found_no_word, done && result.found, result.word_after == '0)

endmodule

bind bitmap_select_engine bse_checker u_bse_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ----- tb/tb_bitmap_select_engine.sv -----
// Self-checking testbench for bitmap_select_engine: a directed table, then random beats.
// Depends on bse_pkg and the engine RTL; results are checked against a local bitmap predictor.
module tb_bitmap_select_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import bse_pkg::*;

  localparam int NWORDS    = WORD_COUNT_DEF;
  localparam int NROWS     = NWORDS * 64;
  localparam int MAX_CYCLE = 3000000;
  localparam int DRAIN     = NWORDS + 16;
  localparam int NRAND     = 560;

  typedef struct {
    cmd_t    c;
    bit      typed;
    result_t r;
  } dir_row_t;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  cmd_t    cmd;
  logic    done;
  result_t result;

  bit [63:0]   bitmap_shadow [NWORDS];
  result_t     pending_results [$];
  int unsigned err_cnt;
  int unsigned cycle_cnt;

  bitmap_select_engine u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h want %h (cycle %0d)", what, got, want, cycle_cnt);
    err_cnt++;
  endtask

  // Applies one operation to the shadow bitmap and returns the result it should give.
  function automatic result_t apply_bitmap_op(cmd_t c);
    result_t     r;
    bit [63:0]   v;
    int          k;
    int          stop;
    int unsigned n;
    r = '0;
    n = 0;
    case (c.mode)
      MODE_SET: begin
        v = bitmap_shadow[c.row_index[15:6]];
        v[c.row_index[5:0]] = c.bit_value;
        bitmap_shadow[c.row_index[15:6]] = v;
        r.word_after = v;
      end
      MODE_COMBINE: begin
        v = bitmap_shadow[c.word_index];
        case (c.combine_op)
          COP_AND:    v = v & c.operand_word;
          COP_OR:     v = v | c.operand_word;
          COP_ANDNOT: v = v & ~c.operand_word;
          COP_XOR:    v = v ^ c.operand_word;
          COP_ORNOT:  v = v | ~c.operand_word;
          COP_COPY:   v = c.operand_word;
          default:    v = v;
        endcase
        bitmap_shadow[c.word_index] = v;
        r.word_after = v;
      end
      MODE_FILL:
        for (k = 0; k < NWORDS; k++) bitmap_shadow[k] = {8{c.fill_byte}};
      MODE_INVERT:
        for (k = 0; k < NWORDS; k++) bitmap_shadow[k] = ~bitmap_shadow[k];
      MODE_NEXT:
        if (c.row_index <= c.scan_limit) begin
          stop = (c.scan_limit < NROWS) ? c.scan_limit : NROWS;
          for (k = c.row_index; k < stop && !r.found; k++)
            if (bitmap_shadow[k >> 6][k % 64]) begin
              r.found = 1'b1;
              r.position = 17'(k);
            end
        end
      MODE_PREV:
        if (c.row_index <= c.scan_limit) begin
          for (k = c.row_index; k >= 0 && !r.found; k--)
            if (bitmap_shadow[k >> 6][k % 64]) begin
              r.found = 1'b1;
              r.position = 17'(k);
            end
        end
      MODE_LAST: begin
        stop = c.end_is_last ? NWORDS - 1 : c.word_index;
        for (k = stop; k >= int'(c.first_word) && !r.found; k--)
          if (bitmap_shadow[k] != 64'd0) begin
            r.found = 1'b1;
            r.position = 17'(k);
          end
      end
      MODE_COUNT: begin
        for (k = 0; k < NWORDS; k++) n += $countones(bitmap_shadow[k]);
        r.position = (n > 131071) ? 17'h1FFFF : 17'(n);
      end
      default: ;
    endcase
    r.all_clear = 1'b1;
    for (k = 0; k < NWORDS; k++)
      if (bitmap_shadow[k] != 64'd0) r.all_clear = 1'b0;
    return r;
  endfunction

  function automatic cmd_t mk_cmd(logic [3:0] m, logic [15:0] row, logic bv,
                                  logic [9:0] widx, logic [63:0] opw, logic [2:0] cop,
                                  logic [7:0] fb, logic [16:0] lim, logic [9:0] fw,
                                  logic eil);
    cmd_t c;
    c = '{m, row, bv, widx, opw, cop, fb, lim, fw, eil};
    return c;
  endfunction

  function automatic result_t mk_res(logic f, logic [16:0] p, logic [63:0] wa, logic clr);
    result_t r;
    r = '{f, p, wa, clr};
    return r;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t         c;
    logic [159:0] raw;
    int unsigned  p;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    c = raw[$bits(cmd_t)-1:0];
    p = $urandom_range(0, 99);
    if (p < 30) begin
      c.mode = MODE_SET;
      c.bit_value = ($urandom_range(0, 3) != 0);
    end else if (p < 52) begin
      c.mode = MODE_COMBINE;
    end else if (p < 74) begin
      c.mode = (p < 64) ? MODE_NEXT : MODE_PREV;
      case ($urandom_range(0, 9))
        0, 1:    c.scan_limit = 17'($urandom_range(0, 131071));
        2, 3, 4: c.scan_limit = 17'($urandom_range(0, NROWS));
        default: c.scan_limit = 17'(c.row_index + $urandom_range(0, 4096));
      endcase
    end else if (p < 80) begin
      c.mode = MODE_LAST;
      if ($urandom_range(0, 1)) c.first_word = 10'($urandom_range(0, c.word_index));
    end else if (p < 83) begin
      c.mode = MODE_FILL;
      case ($urandom_range(0, 9))
        0: c.fill_byte = 8'hFF;
        1: c.fill_byte = 8'hAA;
        2: c.fill_byte = 8'h55;
        3, 4, 5, 6: c.fill_byte = 8'h00;
        default: ;
      endcase
    end else if (p < 85) c.mode = MODE_INVERT;
    else if (p < 89) c.mode = MODE_EMPTY;
    else if (p < 94) c.mode = MODE_COUNT;
    else c.mode = 4'($urandom_range(9, 15));
    return c;
  endfunction

  // Holds start until the engine takes the beat, then records what it should return.
  task automatic send_beat(input cmd_t c, input bit typed, input result_t want);
    result_t r;
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    r = apply_bitmap_op(c);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic maybe_idle(input bit allow);
    if (allow && $urandom_range(0, 99) < 36) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", 64'd1, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (result.found !== want.found)
          report_mismatch("found", result.found, want.found);
        if (result.position !== want.position)
          report_mismatch("position", result.position, want.position);
        if (result.word_after !== want.word_after)
          report_mismatch("word_after", result.word_after, want.word_after);
        if (result.all_clear !== want.all_clear)
          report_mismatch("all_clear", result.all_clear, want.all_clear);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_tbl [$];
    result_t  none;
    int       i;
    none = '0;
    err_cnt = 0;
    cycle_cnt = 0;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    for (i = 0; i < NWORDS; i++) bitmap_shadow[i] = '0;

    dir_tbl.push_back('{mk_cmd(MODE_EMPTY, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                        mk_res(0, 0, 0, 1)});
    dir_tbl.push_back('{mk_cmd(MODE_COUNT, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                        mk_res(0, 0, 0, 1)});
    dir_tbl.push_back('{mk_cmd(MODE_NEXT, 0, 0, 0, 0, 0, 0, 17'd65536, 0, 0), 1,
                        mk_res(0, 0, 0, 1)});
    dir_tbl.push_back('{mk_cmd(MODE_SET, 0, 1, 0, 0, 0, 0, 0, 0, 0), 1,
                        mk_res(0, 0, 64'd1, 0)});
    dir_tbl.push_back('{mk_cmd(MODE_SET, 16'hFFFF, 1, 0, 0, 0, 0, 0, 0, 0), 1,
                        mk_res(0, 0, 64'h8000_0000_0000_0000, 0)});
    dir_tbl.push_back('{mk_cmd(MODE_NEXT, 1, 0, 0, 0, 0, 0, 17'h1FFFF, 0, 0), 0, none});
    // A start row above the limit never finds anything.
    dir_tbl.push_back('{mk_cmd(MODE_NEXT, 5, 0, 0, 0, 0, 0, 4, 0, 0), 1,
                        mk_res(0, 0, 0, 0)});
    dir_tbl.push_back('{mk_cmd(MODE_PREV, 16'hFFFF, 0, 0, 0, 0, 0, 17'hFFFF, 0, 0), 0, none});
    dir_tbl.push_back('{mk_cmd(MODE_PREV, 10, 0, 0, 0, 0, 0, 5, 0, 0), 1,
                        mk_res(0, 0, 0, 0)});
    for (i = 0; i < 8; i++)
      dir_tbl.push_back('{mk_cmd(MODE_COMBINE, 0, 0, 3, 64'hF0F0_1234_5678_9ABC ^ i,
                                 i, 0, 0, 0, 0), 0, none});
    dir_tbl.push_back('{mk_cmd(MODE_COMBINE, 0, 0, 10'd1023, '1, COP_COPY, 0, 0, 0, 0), 1,
                        mk_res(0, 0, '1, 0)});
    dir_tbl.push_back('{mk_cmd(MODE_LAST, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1,
                        mk_res(1, 17'd1023, 0, 0)});
    dir_tbl.push_back('{mk_cmd(MODE_LAST, 0, 0, 100, 0, 0, 0, 0, 900, 0), 1,
                        mk_res(0, 0, 0, 0)});
    dir_tbl.push_back('{mk_cmd(MODE_FILL, 0, 0, 0, 0, 0, 8'hAA, 0, 0, 0), 0, none});
    dir_tbl.push_back('{mk_cmd(MODE_COUNT, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                        mk_res(0, 17'd32768, 0, 0)});
    dir_tbl.push_back('{mk_cmd(MODE_INVERT, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none});
    dir_tbl.push_back('{mk_cmd(MODE_FILL, 0, 0, 0, 0, 0, 8'hFF, 0, 0, 0), 0, none});
    dir_tbl.push_back('{mk_cmd(MODE_COUNT, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                        mk_res(0, 17'd65536, 0, 0)});
    // Undefined modes leave the bitmap alone and report only all_clear.
    dir_tbl.push_back('{mk_cmd(4'd9, 16'h1234, 1, 5, '1, 1, 8'h55, 7, 1, 1), 1,
                        mk_res(0, 0, 0, 0)});
    dir_tbl.push_back('{mk_cmd(4'd15, 16'hFFFF, 1, '1, '1, 7, 8'hFF, '1, '1, 1), 1,
                        mk_res(0, 0, 0, 0)});
    dir_tbl.push_back('{mk_cmd(MODE_FILL, 0, 0, 0, 0, 0, 8'h00, 0, 0, 0), 1,
                        mk_res(0, 0, 0, 1)});

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tbl[i]) begin
      send_beat(dir_tbl[i].c, dir_tbl[i].typed, dir_tbl[i].r);
      maybe_idle(1'b1);
    end

    for (i = 0; i < NRAND; i++) begin
      send_beat(random_cmd(), 1'b0, none);
      if (i == 400) begin
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end else begin
        maybe_idle(i < 200 || i > 330);
      end
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
